// File: src/rrpq_pkg.sv
// ----------------------------------------------------------------------------
// rrpq_pkg
// Shared types and constants for the round-robin process queue: field widths,
// action and status codes, controller states, the entry word and cell controls.
// ----------------------------------------------------------------------------
package rrpq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PID_W     = 22;
  localparam int SER_W     = 16;
  localparam int ACT_W     = 2;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ROTATE = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [SER_W-1:0] ser;
  } entry_t;

  // Per-cell command: match, scan, shift and load
  typedef struct packed {
    logic match;
    logic scan;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: src/rrpq_cell.sv
// ----------------------------------------------------------------------------
// rrpq_cell
// One queue slot: holds an entry, compares it against the search key, and
// carries one bit of the first-match prefix. Takes its right neighbor's entry
// on a shift and a fresh entry on a load.
// ----------------------------------------------------------------------------
module rrpq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rrpq_pkg::cell_ctl_t       ctl,
  input  logic                      valid,
  input  logic                      by_serial,
  input  logic [rrpq_pkg::PID_W-1:0] key_pid,
  input  logic [rrpq_pkg::SER_W-1:0] key_ser,
  input  rrpq_pkg::entry_t          nb_ent,
  input  rrpq_pkg::entry_t          load_ent,
  input  logic                      pre_nb,
  output rrpq_pkg::entry_t          ent,
  output logic                      pre
);
  import rrpq_pkg::*;

  entry_t ent_r;
  logic   pre_r;
  logic   hit;

  // Compare the held entry against the key
  assign hit = valid & (by_serial ? (ent_r.ser == key_ser) : (ent_r.pid == key_pid));

  // Capture the hit, then widen it toward the tail one prefix level a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= 1'b0;
    end else if (ctl.match) begin
      pre_r <= hit;
    end else if (ctl.scan) begin
      pre_r <= pre_r | pre_nb;
    end
  end

  // Load wins over shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent_r <= load_ent;
    end else if (ctl.shift) begin
      ent_r <= nb_ent;
    end
  end

  assign ent = ent_r;
  assign pre = pre_r;

endmodule

// File: src/round_robin_process_queue.sv
// Flow: an accepted word passes S_MATCH, then S_SCAN for remove and lookup on a
//   non-empty queue, then S_APPLY, which waits while a result is held under out_stall.
// Handshake: one word at a time; the next word is taken the cycle the
//   controller returns to idle.
//   The search time is set by the first-match prefix, one level per cycle.
// Reset: synchronous, active low; empties the queue and zeroes the serial counter.
// ----------------------------------------------------------------------------
// round_robin_process_queue
// Ordered round-robin ready queue built as a row of slot cells. Every cell
// matches in parallel; a log-step prefix picks the entry nearest the head,
// and removal closes the gap by shifting the cells behind it by one.
// ----------------------------------------------------------------------------
module round_robin_process_queue #(
  parameter int DEPTH = rrpq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rrpq_pkg::ACT_W-1:0]      in_action,
  input  logic [rrpq_pkg::PID_W-1:0]      in_proc_pid,
  input  logic [rrpq_pkg::SER_W-1:0]      in_lookup_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rrpq_pkg::ST_W-1:0]       out_status,
  output logic [rrpq_pkg::PID_W-1:0]      out_result_pid,
  output logic [rrpq_pkg::SER_W-1:0]      out_result_id,
  output logic [rrpq_pkg::CNT_OUT_W-1:0]  out_entry_count
);
  import rrpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LVLS  = $clog2(DEPTH);
  localparam int LVL_W = (LVLS > 1) ? $clog2(LVLS) : 1;

  // Controller and item registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SER_W-1:0] serial_r, serial_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  action_t          act_r;
  logic [PID_W-1:0] key_pid_r;
  logic [SER_W-1:0] key_ser_r;

  // Output register
  logic                 out_valid_r;
  status_t              out_status_r;
  entry_t               out_ent_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  // Cell row
  entry_t           cell_ent [DEPTH];
  logic [DEPTH-1:0] pre_vec, pre_sh, first_vec, valid_vec;
  logic [DEPTH-1:0] match_v, scan_v, shift_v, load_v;
  entry_t           load_ent, sel_ent, res_ent;
  status_t          res_status;

  logic accept, out_free, apply_go, found, is_search;

  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign apply_go  = (state_r == S_APPLY) & out_free;
  assign found     = pre_vec[DEPTH-1];
  assign is_search = (act_r == ACT_REMOVE) || (act_r == ACT_LOOKUP);
  assign in_stall  = (state_r != S_IDLE);

  // Occupied slots
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = (CNT_W'(i) < count_r);
    end
  end

  // Prefix neighbor at distance 2^level
  always_comb begin
    pre_sh = '0;
    for (int k = 0; k < LVLS; k++) begin
      if (lvl_r == LVL_W'(k)) begin
        pre_sh = pre_vec << (1 << k);
      end
    end
  end

  // Pick the matching entry nearest the head
  assign first_vec = pre_vec & ~(pre_vec << 1);

  always_comb begin
    sel_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        sel_ent = sel_ent | cell_ent[i];
      end
    end
  end

  // Cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nb;

    assign ctl = '{match: match_v[g], scan: scan_v[g], shift: shift_v[g], load: load_v[g]};

    if (g == DEPTH - 1) begin : g_last
      assign nb = cell_ent[g];
    end else begin : g_mid
      assign nb = cell_ent[g+1];
    end

    rrpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .valid     (valid_vec[g]),
      .by_serial (act_r == ACT_LOOKUP),
      .key_pid   (key_pid_r),
      .key_ser   (key_ser_r),
      .nb_ent    (nb),
      .load_ent  (load_ent),
      .pre_nb    (pre_sh[g]),
      .ent       (cell_ent[g]),
      .pre       (pre_vec[g])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = (is_search && (count_r != '0)) ? S_SCAN : S_APPLY;
      end
      S_SCAN: begin
        if (lvl_r == LVL_W'(LVLS - 1)) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell commands, result and state updates
  always_comb begin
    match_v    = '0;
    scan_v     = '0;
    shift_v    = '0;
    load_v     = '0;
    load_ent   = '0;
    lvl_nxt    = lvl_r;
    count_nxt  = count_r;
    serial_nxt = serial_r;
    res_status = ST_OK;
    res_ent    = '0;
    unique case (state_r)
      S_IDLE: begin
      end
      S_MATCH: begin
        match_v = '1;
        lvl_nxt = '0;
      end
      S_SCAN: begin
        scan_v  = '1;
        lvl_nxt = lvl_r + 1'b1;
      end
      S_APPLY: begin
        if (act_r == ACT_ENQ) begin
          if (count_r == CNT_W'(DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            load_ent = '{pid: key_pid_r, ser: serial_r};
            for (int i = 0; i < DEPTH; i++) begin
              load_v[i] = apply_go & (CNT_W'(i) == count_r);
            end
            res_ent    = load_ent;
            count_nxt  = count_r + 1'b1;
            serial_nxt = serial_r + 1'b1;
          end
        end else if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          unique case (act_r)
            ACT_ROTATE: begin
              // Head goes to the last occupied slot, the rest move up
              load_ent = cell_ent[0];
              shift_v  = {DEPTH{apply_go}};
              for (int i = 0; i < DEPTH; i++) begin
                load_v[i] = apply_go & (CNT_W'(i) == count_r - 1'b1);
              end
              res_ent = cell_ent[0];
            end
            ACT_REMOVE: begin
              if (found) begin
                shift_v   = pre_vec & {DEPTH{apply_go}};
                res_ent   = sel_ent;
                count_nxt = count_r - 1'b1;
              end else begin
                res_status = ST_NOTFOUND;
              end
            end
            ACT_LOOKUP: begin
              if (found) begin
                res_ent = sel_ent;
              end else begin
                res_status = ST_NOTFOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      serial_r <= '0;
      lvl_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      if (apply_go) begin
        count_r  <= count_nxt;
        serial_r <= serial_nxt;
      end
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= action_t'(in_action);
      key_pid_r <= in_proc_pid;
      key_ser_r <= in_lookup_id;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_status_r <= res_status;
      out_ent_r    <= res_ent;
      out_count_r  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_pid  = out_ent_r.pid;
  assign out_result_id   = out_ent_r.ser;
  assign out_entry_count = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result word raised outside apply");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && is_search |-> $onehot0(first_vec))
    else $error("more than one first match");

  a_serial_with_enq: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go && (serial_nxt != serial_r) |-> (count_nxt == count_r + 1'b1))
    else $error("serial advanced without an enqueue");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (state_r == S_SCAN) || (state_r == S_APPLY))
    else $error("search left before apply");

endmodule

// File: tb/sv/round_robin_process_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_process_queue_test
// Self-checking bench for the round-robin process queue. A driver offers words
// from a pending list; on each accept a behavioral queue model predicts the
// result. A monitor checks every result word, field by field, in order. The run
// covers empty and full queues, duplicate process numbers, and random phases
// with varied mixes.
// ----------------------------------------------------------------------------
module round_robin_process_queue_test;
  import rrpq_pkg::*;

  localparam int SLOTS       = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [PID_W-1:0] PID_MAX = '1;
  localparam logic [SER_W-1:0] SER_MAX = '1;

  typedef struct {
    action_t          act;
    logic [PID_W-1:0] pid;
    logic [SER_W-1:0] key;
  } queue_word_t;

  typedef struct {
    status_t              status;
    logic [PID_W-1:0]     pid;
    logic [SER_W-1:0]     ser;
    logic [CNT_OUT_W-1:0] count;
  } queue_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action    = '0;
  logic [PID_W-1:0]     in_proc_pid  = '0;
  logic [SER_W-1:0]     in_lookup_id = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [ST_W-1:0]      out_status;
  logic [PID_W-1:0]     out_result_pid;
  logic [SER_W-1:0]     out_result_id;
  logic [CNT_OUT_W-1:0] out_entry_count;

  // Stimulus and expectations
  queue_word_t   pending_words[$];
  queue_result_t owed_results[$];

  // Behavioral copy of the queue
  logic [PID_W-1:0] slot_pid[SLOTS];
  logic [SER_W-1:0] slot_ser[SLOTS];
  int               fill        = 0;
  logic [SER_W-1:0] serial_ctr  = '0;

  int mismatches    = 0;
  int cycles        = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_cycles   = 0;
  int calm_results  = 0;
  bit pressure_done = 1'b0;

  round_robin_process_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_proc_pid    (in_proc_pid),
    .in_lookup_id   (in_lookup_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_result_pid (out_result_pid),
    .out_result_id  (out_result_id),
    .out_entry_count(out_entry_count)
  );

  always #6 clk = ~clk;

  // Print the first 100 mismatches, keep counting the rest
  task automatic flag_mismatch(input string what);
    if (mismatches < 100) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
    mismatches++;
  endtask

  // Most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drop slot k and close the gap behind it
  task automatic drop_slot(input int k);
    for (int i = k; i + 1 < fill; i++) begin
      slot_pid[i] = slot_pid[i + 1];
      slot_ser[i] = slot_ser[i + 1];
    end
    fill--;
  endtask

  // Apply one word to the queue copy and produce its result
  task automatic step_ready_queue(input queue_word_t w, output queue_result_t res);
    int hit;
    logic [PID_W-1:0] head_pid;
    logic [SER_W-1:0] head_ser;
    hit = -1;
    res.status = ST_OK;
    res.pid    = '0;
    res.ser    = '0;
    if (w.act == ACT_ENQ) begin
      if (fill >= SLOTS) begin
        res.status = ST_FULL;
      end else begin
        slot_pid[fill] = w.pid;
        slot_ser[fill] = serial_ctr;
        fill++;
        res.pid    = w.pid;
        res.ser    = serial_ctr;
        serial_ctr = serial_ctr + 1'b1;
      end
    end else if (fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      case (w.act)
        ACT_REMOVE: begin
          for (int i = 0; i < fill && hit < 0; i++) begin
            if (slot_pid[i] == w.pid) hit = i;
          end
          if (hit < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.pid = slot_pid[hit];
            res.ser = slot_ser[hit];
            drop_slot(hit);
          end
        end
        ACT_ROTATE: begin
          head_pid = slot_pid[0];
          head_ser = slot_ser[0];
          drop_slot(0);
          slot_pid[fill] = head_pid;
          slot_ser[fill] = head_ser;
          fill++;
          res.pid = head_pid;
          res.ser = head_ser;
        end
        default: begin
          for (int i = 0; i < fill && hit < 0; i++) begin
            if (slot_ser[i] == w.key) hit = i;
          end
          if (hit < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.pid = slot_pid[hit];
            res.ser = slot_ser[hit];
          end
        end
      endcase
    end
    res.count = CNT_OUT_W'(fill);
  endtask

  task automatic offer_word(input action_t act, input logic [PID_W-1:0] pid,
                            input logic [SER_W-1:0] key);
    queue_word_t w;
    w.act = act;
    w.pid = pid;
    w.key = key;
    pending_words.push_back(w);
  endtask

  // Wait until every word is sent and every result is back
  task automatic wait_drained();
    while (pending_words.size() > 0 || owed_results.size() > 0 || in_valid) begin
      @(posedge clk);
    end
  endtask

  // One random phase; lookup takes whatever weight is left
  task automatic fill_random_phase(input int n, input int w_enq, input int w_rem,
                                   input int w_rot);
    logic [PID_W-1:0] pool[6];
    logic [SER_W-1:0] base;
    logic [PID_W-1:0] pid;
    logic [SER_W-1:0] key;
    action_t act;
    int r;
    base = serial_ctr;
    foreach (pool[i]) pool[i] = PID_W'($urandom());
    if ($urandom_range(0, 1)) pool[0] = '0;
    if ($urandom_range(0, 1)) pool[1] = PID_MAX;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < w_enq) act = ACT_ENQ;
      else if (r < w_enq + w_rem) act = ACT_REMOVE;
      else if (r < w_enq + w_rem + w_rot) act = ACT_ROTATE;
      else act = ACT_LOOKUP;
      pid = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)] : PID_W'($urandom());
      r = $urandom_range(0, 99);
      if (r < 70) key = SER_W'(int'(base) - int'($urandom_range(1, 48)));
      else if (r < 80) key = SER_W'(int'(base) + int'($urandom_range(0, 120)));
      else key = SER_W'($urandom());
      offer_word(act, pid, key);
    end
  endtask

  // Driver: offer pending words, predict on each accept
  always @(posedge clk) begin : driver
    queue_word_t   w;
    queue_result_t res;
    bit            accepted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && !in_stall;
      if (accepted) begin
        w.act = action_t'(in_action);
        w.pid = in_proc_pid;
        w.key = in_lookup_id;
        step_ready_queue(w, res);
        owed_results.push_back(res);
      end
      if (!in_valid || accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_valid     <= 1'b1;
          in_action    <= w.act;
          in_proc_pid  <= w.pid;
          in_lookup_id <= w.key;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word, then decide the stall for the next cycle
  always @(posedge clk) begin : monitor
    queue_result_t want;
    logic          stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result word with none expected");
        end else begin
          want = owed_results.pop_front();
          if (out_status != want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_result_pid != want.pid)
            flag_mismatch($sformatf("result_pid %0h, expected %0h", out_result_pid, want.pid));
          if (out_result_id != want.ser)
            flag_mismatch($sformatf("result_id %0h, expected %0h", out_result_id, want.ser));
          if (out_entry_count != want.count)
            flag_mismatch($sformatf("entry_count %0d, expected %0d", out_entry_count,
                                    want.count));
        end
        calm_results++;
        // Hold off once for a long stretch so the block backs up
        if (calm_results == 100 && !pressure_done) begin
          hold_cycles   = 400;
          pressure_done = 1'b1;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if ($urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[round_robin_process_queue] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: remove, rotate and lookup all report empty
    offer_word(ACT_REMOVE, '0, '0);
    offer_word(ACT_ROTATE, PID_MAX, SER_MAX);
    offer_word(ACT_LOOKUP, '0, '0);
    // Single entry: rotate reports it and leaves it in place
    offer_word(ACT_ENQ, PID_MAX, SER_MAX);
    offer_word(ACT_ROTATE, '0, '0);
    offer_word(ACT_LOOKUP, '0, '0);
    // No match on remove and lookup
    offer_word(ACT_REMOVE, '0, '0);
    offer_word(ACT_LOOKUP, PID_MAX, SER_MAX);
    // Duplicate process numbers: remove takes the one nearest the head
    offer_word(ACT_ENQ, '0, '0);
    offer_word(ACT_ENQ, PID_MAX, '0);
    offer_word(ACT_REMOVE, PID_MAX, '0);
    // Fill to the top; the last enqueues meet a full queue, and a rotate follows
    for (int i = 0; i < SLOTS - 1; i++) begin
      offer_word(ACT_ENQ, (i % 2) ? (22'h155555 ^ PID_W'(i)) : (22'h2AAAAA ^ PID_W'(i)),
                 SER_W'($urandom()));
    end
    offer_word(ACT_ENQ, 22'h123456, '0);
    offer_word(ACT_ROTATE, '0, '0);
    // Remove a process number that is not in the queue
    offer_word(ACT_REMOVE, 22'h155555 ^ PID_W'(SLOTS - 2), '0);
    wait_drained();

    // Random phases with shifting mixes: balanced, filling, draining, rotating, then two more mixes
    fill_random_phase(100, 35, 25, 15);
    wait_drained();
    fill_random_phase(100, 60, 15, 10);
    wait_drained();
    fill_random_phase(100, 20, 45, 15);
    wait_drained();
    fill_random_phase(100, 30, 20, 30);
    wait_drained();
    fill_random_phase(100, 45, 20, 10);
    wait_drained();
    fill_random_phase(100, 25, 35, 10);
    wait_drained();

    // Let any stray result show up
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[round_robin_process_queue] OK");
    end else begin
      $display("[round_robin_process_queue] ERROR");
    end
    $finish;
  end

endmodule
